>>> src/palette_nearest_color_search_macros.svh
// ----------------------------------------------------------------------------
// Palette nearest colour search: assertion macros
// Shared concurrent assertion macros; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PNCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PNCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PNCS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PNCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/pncs_pkg.sv
// ----------------------------------------------------------------------------
// Palette nearest colour search package
// Shared widths, operation codes and the colour type.
// ----------------------------------------------------------------------------
`default_nettype none

package pncs_pkg;

  localparam int COMP_W              = 6;
  localparam int SQ_W                = 2 * COMP_W;
  localparam int DIST_W              = 14;
  localparam int INDEX_W             = 8;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(64 * 64);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } colour_t;

endpackage

`default_nettype wire

>>> src/pncs_palette_ram.sv
// ----------------------------------------------------------------------------
// Palette store
// Single write port, single registered read port colour memory.
// ----------------------------------------------------------------------------
`default_nettype none

module pncs_palette_ram #(
  parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire pncs_pkg::colour_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output pncs_pkg::colour_t     rd_data
);

  pncs_pkg::colour_t mem [PALETTE_ENTRIES];
  pncs_pkg::colour_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/pncs_dist_unit.sv
// ----------------------------------------------------------------------------
// Distance unit
// Squared Euclidean distance between one palette entry and the query colour.
// ----------------------------------------------------------------------------
`default_nettype none

module pncs_dist_unit (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire pncs_pkg::colour_t entry,
  input  wire pncs_pkg::colour_t query,
  output logic [pncs_pkg::DIST_W-1:0] distance
);

  logic [pncs_pkg::SQ_W-1:0] sq_red_r, sq_green_r, sq_blue_r;

  function automatic logic [pncs_pkg::SQ_W-1:0] sq_diff(
    input pncs_pkg::comp_t a,
    input pncs_pkg::comp_t b
  );
    pncs_pkg::comp_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return pncs_pkg::SQ_W'(d) * pncs_pkg::SQ_W'(d);
  endfunction

  // The three squares are registered; the sum follows in the compare cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_red_r   <= sq_diff(entry.red,   query.red);
      sq_green_r <= sq_diff(entry.green, query.green);
      sq_blue_r  <= sq_diff(entry.blue,  query.blue);
    end
  end

  // At most 3 * 63 * 63 = 11907, so the sum never overflows.
  assign distance = pncs_pkg::DIST_W'(sq_red_r) + pncs_pkg::DIST_W'(sq_green_r)
                  + pncs_pkg::DIST_W'(sq_blue_r);

endmodule

`default_nettype wire

>>> src/palette_nearest_color_search.sv
// ----------------------------------------------------------------------------
// Palette nearest colour search
// Holds a colour palette and finds the entry closest to a query colour.
//
// Input channel (in_valid / in_stall) carries one transaction per item. A
// write transaction (operation 0) stores red, green and blue at entry_index
// and gives no result; indexes beyond the palette are dropped. A query
// transaction (operation 1) starts a scan of every entry, one per cycle
// through the palette memory read port and a shared distance unit. A query
// stalls the input until its result has been loaded into the result
// register, so a new transaction is taken only after the last query is through.
// The scan keeps the first entry whose distance is strictly below the best
// so far, starting from distance_limit; with no such entry the result is 0.
// One result transaction per query appears on out_valid / out_nearest_index
// and is held while out_stall is high; writes are still taken meanwhile,
// and a following query scans but waits before delivering its own result.
// The configuration channel writes distance_limit and is ready only while
// no query is in progress. Reset (rst_n, synchronous) returns the limit to
// 4096 and clears all control state; palette contents must be rewritten.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_nearest_color_search_macros.svh"

module palette_nearest_color_search #(
  parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_operation,
  input  wire logic [pncs_pkg::INDEX_W-1:0]  in_entry_index,
  input  wire logic [pncs_pkg::COMP_W-1:0]   in_red,
  input  wire logic [pncs_pkg::COMP_W-1:0]   in_green,
  input  wire logic [pncs_pkg::COMP_W-1:0]   in_blue,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pncs_pkg::INDEX_W-1:0]       out_nearest_index,
  // Configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pncs_pkg::DIST_W-1:0]   cfg_distance_limit
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  // Read-issue and distance stage valid flags with their entry indexes.
  logic          rd_vld_r, dist_vld_r;
  logic [AW-1:0] rd_idx_r, dist_idx_r;

  logic [pncs_pkg::DIST_W-1:0] limit_r, limit_nxt;
  logic [pncs_pkg::DIST_W-1:0] best_r, best_nxt;
  logic [AW-1:0]               pick_r, pick_nxt;
  pncs_pkg::colour_t           query_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [pncs_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;

  logic in_accept, query_accept, write_accept;
  logic out_free, emit;
  pncs_pkg::colour_t in_colour, rd_data;
  logic [pncs_pkg::DIST_W-1:0] distance;

  assign in_colour    = '{red: in_red, green: in_green, blue: in_blue};
  assign in_stall     = (state_r != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign query_accept = in_accept && (in_operation == pncs_pkg::OP_QUERY);
  // Writes beyond the configured palette size are dropped.
  assign write_accept = in_accept && (in_operation == pncs_pkg::OP_WRITE)
                        && ({1'b0, in_entry_index}
                            < (pncs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));

  assign cfg_ready = (state_r == ST_IDLE);

  // The result register is free once its current transaction is taken.
  assign out_free = !out_valid_r || !out_stall;
  // The result is emitted once both pipeline stages have emptied and the result register is free.
  assign emit     = (state_r == ST_DRAIN) && !rd_vld_r && !dist_vld_r && out_free;

  pncs_palette_ram #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (write_accept),
    .wr_addr (in_entry_index[AW-1:0]),
    .wr_data (in_colour),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  pncs_dist_unit u_dist (
    .clk      (clk),
    .en       (rd_vld_r),
    .entry    (rd_data),
    .query    (query_r),
    .distance (distance)
  );

  // Sequencer: one read per cycle in SCAN, then let the pipeline drain.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (query_accept) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_ENTRY) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Running minimum; only a strictly smaller distance replaces the best,
  // so the lowest index wins among equal distances. A limit written in the
  // same cycle as the query is already the one that the query starts from.
  always_comb begin
    best_nxt = best_r;
    pick_nxt = pick_r;
    if (query_accept) begin
      best_nxt = limit_nxt;
      pick_nxt = '0;
    end else if (dist_vld_r && (distance < best_r)) begin
      best_nxt = distance;
      pick_nxt = dist_idx_r;
    end
  end

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_distance_limit;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_index_nxt = pncs_pkg::INDEX_W'(pick_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      dist_vld_r  <= 1'b0;
      limit_r     <= pncs_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      dist_vld_r  <= rd_vld_r;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= cnt_r;
    dist_idx_r  <= rd_idx_r;
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    out_index_r <= out_index_nxt;
    if (query_accept) begin
      query_r <= in_colour;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_index_r;

  // A query always starts its scan at entry zero.
  `PNCS_ASSERT_NEXT(a_query_starts_scan, clk, rst_n, query_accept,
                    (state_r == ST_SCAN) && (cnt_r == '0))
  // The distance stage only carries data while a query is in progress.
  `PNCS_ASSERT_NOW(a_pipe_only_busy, clk, rst_n, dist_vld_r, state_r != ST_IDLE)
  // Emitting a result sets out_valid and returns the sequencer to idle.
  `PNCS_ASSERT_NEXT(a_emit_sets_out, clk, rst_n, emit,
                    out_valid_r && (state_r == ST_IDLE))
  // The running best is not above the limit once the scan pipeline has drained.
  `PNCS_ASSERT_NOW(a_best_under_limit, clk, rst_n,
                   (state_r == ST_DRAIN) && !dist_vld_r && !rd_vld_r,
                   best_r <= limit_r)

endmodule

`default_nettype wire

>>> dv/pncs_checker.sv
// ----------------------------------------------------------------------------
// Palette nearest colour search: transaction checker
// Watches the input, result and configuration channels, keeps its own copy
// of the palette and the distance limit, and compares every result against
// the nearest entry that it predicts for the matching query.
// ----------------------------------------------------------------------------
module pncs_checker #(
  parameter int ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic [pncs_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [pncs_pkg::COMP_W-1:0]   in_red,
  input  logic [pncs_pkg::COMP_W-1:0]   in_green,
  input  logic [pncs_pkg::COMP_W-1:0]   in_blue,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pncs_pkg::INDEX_W-1:0]  out_nearest_index,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pncs_pkg::DIST_W-1:0]   cfg_distance_limit,
  output int                            fail_count,
  output int                            pending_results,
  output int                            results_checked
);

  pncs_pkg::colour_t            palette_copy [ENTRIES];
  logic [pncs_pkg::DIST_W-1:0]  limit_copy;
  logic [pncs_pkg::INDEX_W-1:0] expected_index_q [$];
  logic [pncs_pkg::INDEX_W-1:0] oldest_index;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_checked = 0;
    limit_copy      = pncs_pkg::LIMIT_RESET;
  end

  function automatic logic [pncs_pkg::DIST_W-1:0] square_of_gap(pncs_pkg::comp_t a,
                                                                pncs_pkg::comp_t b);
    pncs_pkg::comp_t gap;
    gap = (a >= b) ? pncs_pkg::comp_t'(a - b) : pncs_pkg::comp_t'(b - a);
    return pncs_pkg::DIST_W'(gap) * pncs_pkg::DIST_W'(gap);
  endfunction

  // Scan from entry 0 upward; only a strictly smaller distance replaces the
  // running best, so the first of several equally close entries is kept.
  function automatic logic [pncs_pkg::INDEX_W-1:0] closest_entry(
    pncs_pkg::colour_t query
  );
    logic [pncs_pkg::DIST_W-1:0]  best;
    logic [pncs_pkg::DIST_W-1:0]  gap_sum;
    logic [pncs_pkg::INDEX_W-1:0] pick;
    best = limit_copy;
    pick = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      gap_sum = square_of_gap(palette_copy[i].red, query.red)
              + square_of_gap(palette_copy[i].green, query.green)
              + square_of_gap(palette_copy[i].blue, query.blue);
      if (gap_sum < best) begin
        best = gap_sum;
        pick = pncs_pkg::INDEX_W'(i);
      end
    end
    return pick;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_copy = pncs_pkg::LIMIT_RESET;
      expected_index_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        limit_copy = cfg_distance_limit;

      if (out_valid && !out_stall) begin
        if (expected_index_q.size() == 0) begin
          $error("nearest_index: result %0d arrived with no query outstanding",
                 out_nearest_index);
          fail_count++;
        end else begin
          oldest_index = expected_index_q.pop_front();
          results_checked++;
          if (out_nearest_index !== oldest_index) begin
            $error("nearest_index: expected %0d, actual %0d",
                   oldest_index, out_nearest_index);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_operation == pncs_pkg::OP_QUERY)
          expected_index_q.push_back(closest_entry({in_red, in_green, in_blue}));
        else if (in_entry_index < ENTRIES)
          palette_copy[in_entry_index] = {in_red, in_green, in_blue};
      end
    end
    pending_results = expected_index_q.size();
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Palette nearest colour search: testbench top
// Fills the palette, runs a short directed sequence and then random phases
// of writes and queries under a range of distance limits, with random gaps
// on the input side and random stalls on the result side. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int ENTRIES     = pncs_pkg::PALETTE_ENTRIES_DEF;
  // This limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 2_000_000;
  // Cycles let pass once nothing is expected: a little more than one scan.
  localparam int DRAIN_WAIT  = 300;
  localparam int IDLE_PCT    = 23;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_operation;
  logic [pncs_pkg::INDEX_W-1:0]  in_entry_index;
  pncs_pkg::comp_t               in_red;
  pncs_pkg::comp_t               in_green;
  pncs_pkg::comp_t               in_blue;
  logic                          out_valid;
  logic                          out_stall;
  logic [pncs_pkg::INDEX_W-1:0]  out_nearest_index;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pncs_pkg::DIST_W-1:0]   cfg_distance_limit;

  int fail_count;
  int pending_results;
  int results_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int limit_writes = 0;

  // Idling switches for each side; both are cleared for one whole phase so
  // that the block also sees back-to-back traffic.
  bit send_idle_on  = 1'b1;
  bit stall_idle_on = 1'b1;

  // What the palette holds, kept only so that queries can aim at real entries.
  pncs_pkg::colour_t written_colour [ENTRIES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  palette_nearest_color_search u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entry_index     (in_entry_index),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_nearest_index  (out_nearest_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_distance_limit (cfg_distance_limit)
  );

  pncs_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entry_index     (in_entry_index),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_nearest_index  (out_nearest_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_distance_limit (cfg_distance_limit),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .results_checked    (results_checked)
  );

  // The result side stalls at random, decided afresh at every falling edge.
  // The stall never looks at out_valid, so it lands on every phase of a scan.
  always @(negedge clk)
    out_stall <= stall_idle_on && ($urandom_range(99) < IDLE_PCT);

  // Runaway guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one transaction at a falling edge, after a random number of
  // idle cycles, and returns once it has been taken at a rising edge. Valid
  // is left high so that the next transaction can follow without a gap; the
  // payload is untouched while the block stalls.
  task automatic push_item(input logic op, input logic [pncs_pkg::INDEX_W-1:0] idx,
                           input pncs_pkg::colour_t colour);
    @(negedge clk);
    while (send_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_red         <= colour.red;
    in_green       <= colour.green;
    in_blue        <= colour.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == pncs_pkg::OP_QUERY)
      queries_sent++;
    else
      written_colour[idx] = colour;
  endtask

  // Changes the distance limit. The block must be idle: the input channel is
  // closed, every outstanding result is collected and a short pause covers
  // a write transaction that may still be settling.
  task automatic write_limit(input logic [pncs_pkg::DIST_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_distance_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // A component for a palette entry. Clustered palettes sit close to black,
  // so queries near white land far from every entry and the limit decides.
  function automatic pncs_pkg::comp_t entry_component(input bit clustered);
    int roll;
    roll = $urandom_range(99);
    if (clustered)
      return pncs_pkg::comp_t'($urandom_range(0, 3));
    if (roll < 10)
      return '0;
    if (roll < 20)
      return '1;
    return pncs_pkg::comp_t'($urandom_range(0, 63));
  endfunction

  function automatic pncs_pkg::colour_t entry_colour(input bit clustered);
    pncs_pkg::colour_t c;
    c.red   = entry_component(clustered);
    c.green = entry_component(clustered);
    c.blue  = entry_component(clustered);
    return c;
  endfunction

  // Rewrites every entry, so that the palette is fully defined before any
  // query scans it.
  task automatic refill_palette(input bit clustered);
    for (int i = 0; i < ENTRIES; i++)
      push_item(pncs_pkg::OP_WRITE, pncs_pkg::INDEX_W'(i), entry_colour(clustered));
  endtask

  // A random mix of writes and queries. Queries often copy an existing entry
  // (exact match, and ties where entries repeat), sometimes take a corner of
  // the colour cube, and otherwise roam the full range.
  task automatic run_phase(input int count, input bit clustered);
    pncs_pkg::colour_t            colour;
    logic [pncs_pkg::INDEX_W-1:0] idx;
    int                           roll;
    for (int n = 0; n < count; n++) begin
      idx  = pncs_pkg::INDEX_W'($urandom_range(0, ENTRIES - 1));
      roll = $urandom_range(99);
      if ($urandom_range(99) < 55) begin
        push_item(pncs_pkg::OP_WRITE, idx, entry_colour(clustered));
      end else begin
        if (roll < 30) begin
          colour = written_colour[$urandom_range(0, ENTRIES - 1)];
        end else if (roll < 45) begin
          colour.red   = {pncs_pkg::COMP_W{$urandom_range(0, 1) == 1}};
          colour.green = {pncs_pkg::COMP_W{$urandom_range(0, 1) == 1}};
          colour.blue  = {pncs_pkg::COMP_W{$urandom_range(0, 1) == 1}};
        end else begin
          colour = entry_colour(1'b0);
        end
        push_item(pncs_pkg::OP_QUERY, idx, colour);
      end
    end
  endtask

  initial begin
    // Every input is known from time zero; reset is held low at the start.
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_operation       = pncs_pkg::OP_WRITE;
    in_entry_index     = '0;
    in_red             = '0;
    in_green           = '0;
    in_blue            = '0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_distance_limit = pncs_pkg::LIMIT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first settings run with the limit as reset leaves it.
    refill_palette(1'b0);

    // Directed part: black and white entries, a duplicated colour, exact
    // matches, a query equally far from two entries and near misses.
    push_item(pncs_pkg::OP_WRITE, 8'd0,   '{red: 6'd0,  green: 6'd0,  blue: 6'd0});
    push_item(pncs_pkg::OP_WRITE, 8'd1,   '{red: 6'd0,  green: 6'd0,  blue: 6'd0});
    push_item(pncs_pkg::OP_WRITE, 8'd255, '{red: 6'd63, green: 6'd63, blue: 6'd63});
    push_item(pncs_pkg::OP_WRITE, 8'd10,  '{red: 6'd21, green: 6'd42, blue: 6'd21});
    push_item(pncs_pkg::OP_WRITE, 8'd11,  '{red: 6'd21, green: 6'd42, blue: 6'd21});
    push_item(pncs_pkg::OP_WRITE, 8'd128, '{red: 6'd63, green: 6'd0,  blue: 6'd63});
    push_item(pncs_pkg::OP_QUERY, 8'd255, '{red: 6'd0,  green: 6'd0,  blue: 6'd0});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd63, green: 6'd63, blue: 6'd63});
    push_item(pncs_pkg::OP_QUERY, 8'd170, '{red: 6'd21, green: 6'd42, blue: 6'd21});
    push_item(pncs_pkg::OP_QUERY, 8'd85,  '{red: 6'd63, green: 6'd0,  blue: 6'd63});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd0,  green: 6'd63, blue: 6'd0});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd32, green: 6'd32, blue: 6'd32});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd1,  green: 6'd0,  blue: 6'd0});
    // Entry 0 turns white, so white and near-white queries now tie between
    // entries 0 and 255 and the lower index must win.
    push_item(pncs_pkg::OP_WRITE, 8'd0,   '{red: 6'd63, green: 6'd63, blue: 6'd63});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd62, green: 6'd63, blue: 6'd63});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd0,  green: 6'd0,  blue: 6'd0});
    push_item(pncs_pkg::OP_QUERY, 8'd0,   '{red: 6'd63, green: 6'd63, blue: 6'd63});

    // Widest limit over a mixed palette.
    write_limit('1);
    run_phase(90, 1'b0);

    // A zero limit: no entry can be strictly closer, so every answer is 0.
    write_limit('0);
    run_phase(30, 1'b0);

    // Palette pulled close to black. With the widest limit even the largest
    // distance (black entry against a white query) still selects an entry.
    write_limit('1);
    refill_palette(1'b1);
    run_phase(40, 1'b1);

    // Same palette at the reset limit: far queries find nothing under it.
    write_limit(pncs_pkg::LIMIT_RESET);
    run_phase(40, 1'b1);

    // Limit equal to the largest distance, so black against white just fails.
    write_limit(pncs_pkg::DIST_W'(3 * 63 * 63));
    run_phase(30, 1'b1);

    // A tight limit over a fresh mixed palette.
    write_limit(pncs_pkg::DIST_W'($urandom_range(1, 300)));
    refill_palette(1'b0);
    run_phase(60, 1'b0);

    // A random limit with no idling on either side for the whole phase.
    send_idle_on  = 1'b0;
    stall_idle_on = 1'b0;
    write_limit(pncs_pkg::DIST_W'($urandom_range(0, 16383)));
    run_phase(75, 1'b0);
    send_idle_on  = 1'b1;
    stall_idle_on = 1'b1;

    // Close the input channel, collect what is still owed, then give a late
    // or stray result time to show itself.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Run covered %0d transactions, %0d of them queries, over %0d limit writes;",
             items_sent, queries_sent, limit_writes);
    $display("%0d nearest-entry results were compared in %0d cycles.",
             results_checked, cycle_count);
    if (fail_count == 0 && pending_results == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
